### sv/spsc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the stack pop sequence checker
package spsc_pkg;

    localparam int VAL_W      = 5;           // width of a value and of the length register
    localparam int CNT_W      = VAL_W + 1;   // holds n + 1 for the push counter
    localparam int MAX_LEN    = 16;          // default stack depth
    localparam int TDATA_IN_W = 8;
    localparam int TDATA_OUT_W = 8;
    localparam logic [VAL_W-1:0] LEN_RESET = VAL_W'(16);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_CMP,
        ST_FINISH
    } seq_state_t;

    // verdict of one word, ok in the lowest bit
    typedef struct packed {
        logic done;
        logic ok;
    } result_t;

endpackage

### sv/spsc_ram.sv
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read
module spsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/spsc_seq.sv
`timescale 1ns / 1ps
// sequencer: push loop, top-of-stack compare and per-sequence state
module spsc_seq
    import spsc_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LEN
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [VAL_W-1:0] in_value,
    input  logic [VAL_W-1:0] seq_len,
    input  logic             out_free,
    output logic             res_valid,
    output result_t          res
);

    localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int DW = $clog2(MAX_LENGTH + 1);

    seq_state_t       state_reg, state_next;
    logic [DW-1:0]    depth_reg, depth_next;
    logic [CNT_W-1:0] push_reg, push_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             failed_reg, failed_next;
    logic [VAL_W-1:0] value_reg, value_next;

    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] pos_inc;
    logic             wr_en;
    logic [VAL_W-1:0] rd_data;
    logic             accept;

    // length clamped to 1..MAX_LENGTH
    always_comb begin
        if (seq_len == '0) begin
            n_eff = CNT_W'(1);
        end else if (32'(seq_len) > MAX_LENGTH) begin
            n_eff = CNT_W'(MAX_LENGTH);
        end else begin
            n_eff = CNT_W'(seq_len);
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign pos_inc  = pos_reg + CNT_W'(1);

    spsc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_LENGTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (depth_reg[AW-1:0]),
        .wr_data (push_reg[VAL_W-1:0]),
        .rd_addr (AW'(depth_reg - DW'(1))),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            depth_reg  <= '0;
            push_reg   <= CNT_W'(1);
            pos_reg    <= '0;
            failed_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            depth_reg  <= depth_next;
            push_reg   <= push_next;
            pos_reg    <= pos_next;
            failed_reg <= failed_next;
        end
        value_reg <= value_next;
    end

    always_comb begin
        state_next  = state_reg;
        depth_next  = depth_reg;
        push_next   = push_reg;
        pos_next    = pos_reg;
        failed_next = failed_reg;
        value_next  = value_reg;
        wr_en       = 1'b0;
        res_valid   = 1'b0;
        res.ok      = !failed_reg;
        res.done    = (pos_inc >= n_eff);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    value_next = in_value;
                    if (failed_reg) begin
                        state_next = ST_FINISH;
                    end else if (in_value == '0 || CNT_W'(in_value) > n_eff) begin
                        failed_next = 1'b1;
                        state_next  = ST_FINISH;
                    end else begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_PUSH: begin
                // one push per cycle; the read of the top runs in the last cycle
                if (push_reg <= n_eff && push_reg <= CNT_W'(value_reg)) begin
                    if (depth_reg < DW'(MAX_LENGTH)) begin
                        wr_en      = 1'b1;
                        depth_next = depth_reg + DW'(1);
                    end
                    push_next = push_reg + CNT_W'(1);
                end else if (depth_reg == '0) begin
                    failed_next = 1'b1;
                    state_next  = ST_FINISH;
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (rd_data == value_reg) begin
                    depth_next = depth_reg - DW'(1);
                end else begin
                    failed_next = 1'b1;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                    if (res.done) begin
                        depth_next  = '0;
                        push_next   = CNT_W'(1);
                        pos_next    = '0;
                        failed_next = 1'b0;
                    end else begin
                        pos_next = pos_inc;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/stack_pop_sequence_check.sv
`timescale 1ns / 1ps
// top level of the stack pop sequence checker
// path: an out-of-range word or one after a failure goes from accept straight to the finish state,
//   else through the push state (one ram push a cycle), the compare state unless the stack is empty, and finish
// throughput: one word in flight; s_tready returns when the verdict is registered into m_tvalid,
//   and a word waits longer while m_tready holds off
// reset: synchronous, active low; clears sequence state, length returns to 16, ram not cleared
module stack_pop_sequence_check
    import spsc_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LEN
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input words
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // [4:0] pop_value, [7:5] zero
    // result words
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // [0] ok_so_far, [7:1] zero
    output logic                   m_tlast,   // sequence_done
    // sequence_length register
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [VAL_W-1:0]       cfg_data
);

    logic [VAL_W-1:0] len_reg;
    logic             m_valid_reg;
    result_t          m_res_reg;
    logic             out_free;
    logic             res_valid;
    result_t          res;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= LEN_RESET;
        end else if (cfg_valid) begin
            len_reg <= cfg_data;
        end
    end

    // the sequencer hands on a verdict only while the output register is empty or being read
    assign out_free = !m_valid_reg || m_tready;

    spsc_seq #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata[VAL_W-1:0]),
        .seq_len   (len_reg),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= res_valid;
        end
        if (out_free && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(TDATA_OUT_W - 1)'(0), m_res_reg.ok};
    assign m_tlast  = m_res_reg.done;

endmodule
